// ===== rtl/core/scsa_pkg.sv =====
package scsa_pkg;

  // request commands
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOT_USED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SLOT_STEP      = 2'd0;
  localparam logic [1:0] REG_POOL_COUNT     = 2'd1;
  localparam logic [1:0] REG_SLOTS_PER_POOL = 2'd2;

  // configuration reset values
  localparam logic [12:0] SLOT_STEP_RST      = 13'd128;
  localparam logic [4:0]  POOL_COUNT_RST     = 5'd16;
  localparam logic [6:0]  SLOTS_PER_POOL_RST = 7'd64;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DIV  = 8'b0000_0010,
    S_RDH  = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_CMP  = 8'b0001_0000,
    S_RDA  = 8'b0010_0000,
    S_ALW  = 8'b0100_0000,
    S_FRE  = 8'b1000_0000
  } state_t;

endpackage

// ===== rtl/core/size_class_slot_allocator_unit.sv =====
// Size-class slot allocator. A request is taken when start is high and busy is low; its single
// result appears on status, result_handle and copy_bytes for exactly one cycle with done high,
// and must be taken then. The pool number comes from a restoring divider (size by slot_step, one
// quotient bit a cycle), followed by read-modify-write passes on the used-slot memory, one port
// each way. done rises in the same cycle as busy falls, so the next request can be taken on the
// edge that takes the result. The used-slot map is empty straight after reset (per-pool valid
// bits), so no clearing pass is needed.
module size_class_slot_allocator_unit
  import scsa_pkg::*;
#(
  parameter int MAX_POOLS = 16,
  parameter int MAX_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [15:0] size,
  input  logic [9:0]  handle,
  // result
  output logic        done,
  output logic [1:0]  status,
  output logic [9:0]  result_handle,
  output logic [16:0] copy_bytes
);

  localparam int DEPTH = (MAX_POOLS > 16) ? 16 : MAX_POOLS;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (MAX_SLOTS > 64) ? 64 : MAX_SLOTS;

  // configuration registers
  logic [12:0] slot_step;
  logic [4:0]  pool_count;
  logic [6:0]  slots_per_pool;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_step      <= SLOT_STEP_RST;
      pool_count     <= POOL_COUNT_RST;
      slots_per_pool <= SLOTS_PER_POOL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SLOT_STEP:      slot_step      <= pwdata[12:0];
        REG_POOL_COUNT:     pool_count     <= pwdata[4:0];
        REG_SLOTS_PER_POOL: slots_per_pool <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SLOT_STEP:      prdata = 32'(slot_step);
      REG_POOL_COUNT:     prdata = 32'(pool_count);
      REG_SLOTS_PER_POOL: prdata = 32'(slots_per_pool);
      default:            prdata = '0;
    endcase
  end

  // effective configuration
  logic [12:0] step_e;
  logic [4:0]  pools_e;
  logic [6:0]  slots_e;
  logic [SW-1:0] slot_mask;

  always_comb begin
    step_e  = (slot_step == 13'd0) ? 13'd1 : slot_step;
    pools_e = (pool_count > 5'(DEPTH)) ? 5'(DEPTH) : pool_count;
    slots_e = (slots_per_pool > 7'(SW)) ? 7'(SW) : slots_per_pool;
    for (int i = 0; i < SW; i++) begin
      slot_mask[i] = (7'(i) < slots_e);
    end
  end

  // request registers
  state_t      state;
  logic [1:0]  cmd;
  logic [15:0] size_r;
  logic [9:0]  handle_r;
  logic [15:0] dvd;
  logic [12:0] rem;
  logic [3:0]  cnt;
  logic        h_used;
  logic [16:0] old_size;
  logic [SW-1:0] old_word;

  // used-slot memory with per-pool valid bits
  logic [SW-1:0] used_mem [DEPTH];
  logic [DEPTH-1:0] pool_valid;
  logic [SW-1:0] rdata;
  logic          mem_re, mem_we;
  logic [PW-1:0] mem_raddr, mem_waddr;
  logic [SW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) used_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= used_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_valid <= '0;
    end else if (mem_we) begin
      pool_valid[mem_waddr] <= 1'b1;
    end
  end

  // decode of the request handle and of the pool quotient
  logic [3:0]    hp;
  logic [5:0]    hs;
  logic          hp_ok;
  logic [PW-1:0] hp_idx;
  logic [PW-1:0] q_idx;
  logic          too_big;
  logic [SW-1:0] free_bit;

  always_comb begin
    hp      = handle_r[9:6];
    hs      = handle_r[5:0];
    hp_ok   = (5'(hp) < 5'(DEPTH));
    hp_idx  = hp[PW-1:0];
    q_idx   = dvd[PW-1:0];
    too_big = (dvd >= 16'(pools_e));
    for (int i = 0; i < SW; i++) begin
      free_bit[i] = (hs == 6'(i));
    end
  end

  // handle check
  logic [SW-1:0] chk_word;
  logic [63:0]   chk_word64;
  logic          used_now;

  always_comb begin
    chk_word   = (hp_ok && pool_valid[hp_idx]) ? rdata : '0;
    chk_word64 = 64'(chk_word);
    used_now   = hp_ok && chk_word64[hs];
  end

  // allocation: lowest free slot
  logic [SW-1:0] alw_word;
  logic [SW-1:0] avail;
  logic [SW-1:0] low_bit;
  logic [5:0]    slot_idx;

  always_comb begin
    alw_word = pool_valid[q_idx] ? rdata : '0;
    avail    = slot_mask & ~alw_word;
    low_bit  = avail & (~avail + SW'(1));
    slot_idx = 6'd0;
    for (int i = SW - 1; i >= 0; i--) begin
      if (avail[i]) slot_idx = 6'(i);
    end
  end

  // old slot size, a short multiply
  logic [16:0] old_size_next;
  assign old_size_next = 17'((5'(hp) + 5'd1) * step_e);

  // divider step
  logic [13:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem, dvd[15]};
  assign q_bit  = (rem_sh >= {1'b0, step_e});

  // memory control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = (state == S_RDA) ? q_idx : hp_idx;
    mem_we    = 1'b0;
    mem_waddr = hp_idx;
    mem_wdata = chk_word & ~free_bit;
    unique case (state)
      S_RDH: mem_re = hp_ok;
      S_CHK: mem_we = (cmd == CMD_FREE) && used_now;
      S_RDA: mem_re = 1'b1;
      S_ALW: begin
        mem_we    = (avail != '0);
        mem_waddr = q_idx;
        mem_wdata = alw_word | low_bit;
      end
      S_FRE: begin
        mem_we    = 1'b1;
        mem_wdata = old_word & ~free_bit;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd      <= command;
            size_r   <= size;
            handle_r <= handle;
            dvd      <= size;
            rem      <= '0;
            cnt      <= 4'd15;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= q_bit ? 13'(rem_sh - {1'b0, step_e}) : rem_sh[12:0];
          dvd <= {dvd[14:0], q_bit};
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) state <= S_RDH;
        end
        S_RDH: state <= S_CHK;
        S_CHK: begin
          h_used   <= used_now;
          old_word <= chk_word;
          old_size <= old_size_next;
          case (cmd)
            CMD_ALLOC: state <= S_RDA;
            CMD_REALLOC: state <= used_now ? S_CMP : S_RDA;
            CMD_FREE: begin
              status        <= used_now ? ST_OK : ST_NOT_USED;
              result_handle <= '0;
              copy_bytes    <= '0;
              done          <= 1'b1;
              state         <= S_IDLE;
            end
            default: begin
              status        <= ST_OK;
              result_handle <= '0;
              copy_bytes    <= '0;
              done          <= 1'b1;
              state         <= S_IDLE;
            end
          endcase
        end
        S_CMP: begin
          if (old_size >= {1'b0, size_r}) begin
            // slot already large enough: keep the handle
            status        <= ST_OK;
            result_handle <= handle_r;
            copy_bytes    <= '0;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_RDA;
          end
        end
        S_RDA: begin
          if (too_big || slots_e == 7'd0) begin
            status        <= too_big ? ST_TOO_BIG : ST_FULL;
            result_handle <= '0;
            copy_bytes    <= '0;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            state <= S_ALW;
          end
        end
        S_ALW: begin
          if (avail == '0) begin
            status        <= ST_FULL;
            result_handle <= '0;
            copy_bytes    <= '0;
            done          <= 1'b1;
            state         <= S_IDLE;
          end else if (cmd == CMD_REALLOC && h_used) begin
            // moved: the new pool is always above the old one, so old_word is current
            status        <= ST_OK;
            result_handle <= {dvd[3:0], slot_idx};
            copy_bytes    <= old_size;
            state         <= S_FRE;
          end else begin
            status        <= ST_OK;
            result_handle <= {dvd[3:0], slot_idx};
            copy_bytes    <= '0;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_FRE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
